// File: hdl/osrch_pkg.sv
// Package for the ROM search engine: command codes, item and result types.
// No dependencies; used by osrch_core and one_wire_rom_search.
package osrch_pkg;

	localparam int CODE_W      = 64;
	localparam int FAMILY_BITS = 8;

	typedef enum logic [1:0] {
		CMD_BEGIN = 2'd0,
		CMD_PAIR  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic presence;
		logic id_bit;
		logic cmp_bit;
	} item_t;

	typedef struct packed {
		logic              last_device;
		logic [CODE_W-1:0] rom_code;
		logic              found;
		logic              done_res;
		logic              dir_bit;
		logic              dir_valid;
	} result_t;

endpackage

// File: hdl/osrch_core.sv
// Search state registers and the per-item decision logic.
// Depends on osrch_pkg. State advances on step_en; res is combinational.
module osrch_core #(
	parameter int ROM_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  osrch_pkg::item_t   item,
	output osrch_pkg::result_t res
);
	import osrch_pkg::*;

	localparam int POS_W = $clog2(ROM_BITS + 1);
	localparam int IDX_W = (ROM_BITS > 1) ? $clog2(ROM_BITS) : 1;

	logic [ROM_BITS-1:0] rom_q, rom_n;
	logic [POS_W-1:0]    last_discrep_q, last_discrep_n;
	logic                last_dev_q, last_dev_n;
	logic [POS_W-1:0]    bit_pos_q, bit_pos_n;
	logic [POS_W-1:0]    zero_pos_q, zero_pos_n;
	logic                searching_q, searching_n;

	logic [IDX_W-1:0] idx;
	logic             dir;

	assign idx = IDX_W'(bit_pos_q - POS_W'(1));

	always_comb begin
		rom_n          = rom_q;
		last_discrep_n = last_discrep_q;
		last_dev_n     = last_dev_q;
		bit_pos_n      = bit_pos_q;
		zero_pos_n     = zero_pos_q;
		searching_n    = searching_q;
		dir            = 1'b0;
		res            = '0;
		case (item.cmd)
			CMD_BEGIN: begin
				if (last_dev_q) begin
					last_discrep_n = '0;
					last_dev_n     = 1'b0;
					searching_n    = 1'b0;
					res.done_res   = 1'b1;
				end else if (!item.presence) begin
					rom_n          = '0;
					last_discrep_n = '0;
					last_dev_n     = 1'b0;
					bit_pos_n      = POS_W'(1);
					zero_pos_n     = '0;
					searching_n    = 1'b0;
					res.done_res   = 1'b1;
				end else begin
					searching_n = 1'b1;
					bit_pos_n   = POS_W'(1);
					zero_pos_n  = '0;
				end
			end
			CMD_PAIR: begin
				if (searching_q) begin
					if (item.id_bit && item.cmp_bit) begin
						last_discrep_n = '0;
						last_dev_n     = 1'b0;
						searching_n    = 1'b0;
						res.done_res   = 1'b1;
					end else begin
						if (item.id_bit != item.cmp_bit) begin
							dir = item.id_bit;
						end else begin
							if (bit_pos_q < last_discrep_q) begin
								dir = rom_q[idx];
							end else begin
								dir = (bit_pos_q == last_discrep_q);
							end
							if (!dir) begin
								zero_pos_n = bit_pos_q;
							end
						end
						rom_n[idx]    = dir;
						res.dir_valid = 1'b1;
						res.dir_bit   = dir;
						if (bit_pos_q >= POS_W'(ROM_BITS)) begin
							searching_n    = 1'b0;
							res.done_res   = 1'b1;
							last_discrep_n = zero_pos_n;
							last_dev_n     = last_dev_q | (zero_pos_n == '0);
							res.found      = 1'b1;
							if (rom_n[FAMILY_BITS-1:0] == '0) begin
								last_discrep_n = '0;
								last_dev_n     = 1'b0;
								res.found      = 1'b0;
							end
							bit_pos_n = POS_W'(1);
						end else begin
							bit_pos_n = bit_pos_q + POS_W'(1);
						end
					end
				end
			end
			CMD_CLEAR: begin
				rom_n          = '0;
				last_discrep_n = '0;
				last_dev_n     = 1'b0;
				bit_pos_n      = POS_W'(1);
				zero_pos_n     = '0;
				searching_n    = 1'b0;
			end
			default: begin
			end
		endcase
		res.rom_code    = CODE_W'(rom_n);
		res.last_device = last_dev_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_q          <= '0;
			last_discrep_q <= '0;
			last_dev_q     <= 1'b0;
			bit_pos_q      <= POS_W'(1);
			zero_pos_q     <= '0;
			searching_q    <= 1'b0;
		end else if (step_en) begin
			rom_q          <= rom_n;
			last_discrep_q <= last_discrep_n;
			last_dev_q     <= last_dev_n;
			bit_pos_q      <= bit_pos_n;
			zero_pos_q     <= zero_pos_n;
			searching_q    <= searching_n;
		end
	end

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		searching_q |-> (bit_pos_q != '0) && (bit_pos_q <= POS_W'(ROM_BITS)))
		else $error("bit position out of range during pass");
	a_discrep_range: assert property (@(posedge clk) disable iff (!arst_n)
		last_discrep_q <= POS_W'(ROM_BITS))
		else $error("last discrepancy beyond code length");
	a_last_dev_idle: assert property (@(posedge clk) disable iff (!arst_n)
		last_dev_q |-> !searching_q)
		else $error("pass running after last device found");
`endif

endmodule

// File: hdl/one_wire_rom_search.sv
// Top level of the 1-Wire search ROM decision engine.
// Depends on osrch_pkg and osrch_core.
//
// Usage:
// - Slave channel s_axis: one transaction per command. tuser holds the
//   command (begin pass, bit pair, clear); tdata holds presence and the two
//   bits read from the bus.
// - Master channel m_axis: exactly one result transaction per command,
//   with the direction bit to write, pass end/found flags, the current
//   ROM code and the last-device flag.
// - A command passes the input register, then the result register, before
//   its result is valid. Throughput: one command per clock unless stalled; the
//   state update is a single compare and bit write between the two registers.
// - Reset clears both valid flags and the search state (bit position 1).
// - Receiver stall: the result register holds; the input register takes
//   one more command, after which s_axis_tready drops until the result
//   register drains.
module one_wire_rom_search #(
	parameter int ROM_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [0] presence, [1] id_bit, [2] cmp_bit, [7:3] zero
	input  logic [7:0]  s_axis_tdata,
	// [1:0] cmd
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] dir_valid, [1] dir_bit, [2] done_res, [3] found, [67:4] rom_code,
	// [68] last_device, [71:69] zero
	output logic [71:0] m_axis_tdata
);
	import osrch_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    advance;
	result_t res;
	logic    out_valid_q;
	result_t res_q;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.cmd      <= cmd_t'(s_axis_tuser);
			item_s1.presence <= s_axis_tdata[0];
			item_s1.id_bit   <= s_axis_tdata[1];
			item_s1.cmp_bit  <= s_axis_tdata[2];
		end
	end

	osrch_core #(
		.ROM_BITS(ROM_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(advance),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, res_q.last_device, res_q.rom_code, res_q.found,
		res_q.done_res, res_q.dir_bit, res_q.dir_valid};

`ifndef SYNTHESIS
	a_found_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.found |-> res_q.done_res && res_q.dir_valid)
		else $error("found reported without pass end");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && out_valid_q && !m_axis_tready)
		else $error("input stalled without output back-pressure");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("pending command lost");
`endif

endmodule

// File: tb/sv/one_wire_rom_search_tb.sv
// Self-checking testbench for one_wire_rom_search: directed table, then enumeration of
// random device populations with injected faults, checked against a behavioral predictor.
// Depends on osrch_pkg and the one_wire_rom_search RTL.
`timescale 1ns / 1ps

module one_wire_rom_search_tb;
	import osrch_pkg::*;

	localparam int ROM_BITS = 64;
	localparam int ITEM_TARGET = 900;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [63:0] CODE_MASK = (ROM_BITS >= 64) ? '1 : ((64'd1 << ROM_BITS) - 64'd1);

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;

	one_wire_rom_search #(.ROM_BITS(ROM_BITS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// search state mirror
	logic [63:0] p_rom;
	logic [6:0]  p_last_discrep;
	logic [3:0]  p_family_discrep;
	logic        p_last_dev;
	logic [6:0]  p_bit_pos;
	logic [6:0]  p_zero_pos;
	logic        p_searching;

	result_t expected_results[$];
	result_t last_res;
	logic [63:0] dev_codes [8];

	int  mismatches = 0;
	int  checked = 0;
	int  busy_items = 0;
	int  codes_found = 0;
	int  last_dev_ends = 0;
	int  failed_passes = 0;
	bit  quiet = 0;
	bit  tx_idle_on = 1;
	bit  hold_req = 0;
	bit  held = 0;
	bit  drained = 0;

	typedef struct packed {
		logic [1:0] cmd;
		logic       presence;
		logic       id_bit;
		logic       cmp_bit;
		logic       typed;
		logic       t_done;
	} stim_row_t;

	// cmd, presence, id, cmp, typed, done
	stim_row_t stim_rows [20] = '{
		'{CMD_PAIR,   1'b0, 1'b1, 1'b0, 1'b1, 1'b0},
		'{CMD_UNUSED, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
		'{CMD_BEGIN,  1'b0, 1'b0, 1'b0, 1'b1, 1'b1},
		'{CMD_CLEAR,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
		'{CMD_BEGIN,  1'b1, 1'b0, 1'b0, 1'b1, 1'b0},
		'{CMD_PAIR,   1'b0, 1'b1, 1'b1, 1'b1, 1'b1},
		'{CMD_PAIR,   1'b1, 1'b0, 1'b1, 1'b1, 1'b0},
		'{CMD_BEGIN,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
		'{CMD_PAIR,   1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
		'{CMD_PAIR,   1'b1, 1'b0, 1'b1, 1'b0, 1'b0},
		'{CMD_PAIR,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{CMD_PAIR,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{CMD_BEGIN,  1'b1, 1'b0, 1'b1, 1'b0, 1'b0},
		'{CMD_PAIR,   1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
		'{CMD_PAIR,   1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
		'{CMD_BEGIN,  1'b0, 1'b1, 1'b1, 1'b1, 1'b1},
		'{CMD_BEGIN,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{CMD_PAIR,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{CMD_CLEAR,  1'b0, 1'b0, 1'b0, 1'b1, 1'b0},
		'{CMD_PAIR,   1'b1, 1'b1, 1'b0, 1'b1, 1'b0}
	};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_marks();
		p_last_discrep = '0;
		p_family_discrep = '0;
		p_last_dev = 1'b0;
	endfunction

	function automatic void clear_search();
		p_rom = '0;
		clear_marks();
		p_bit_pos = 7'd1;
		p_zero_pos = '0;
		p_searching = 1'b0;
	endfunction

	function automatic result_t search_step(input logic [1:0] cmd, input logic pres,
			input logic idb, input logic cmpb);
		result_t r;
		logic [63:0] bm;
		logic dir;
		r = '0;
		case (cmd)
			CMD_BEGIN: begin
				if (p_last_dev) begin
					clear_marks();
					p_searching = 1'b0;
					r.done_res = 1'b1;
				end else if (!pres) begin
					clear_search();
					r.done_res = 1'b1;
				end else begin
					p_searching = 1'b1;
					p_bit_pos = 7'd1;
					p_zero_pos = '0;
				end
			end
			CMD_PAIR: begin
				if (p_searching && idb && cmpb) begin
					clear_marks();
					p_searching = 1'b0;
					r.done_res = 1'b1;
				end else if (p_searching) begin
					bm = 64'd1 << 6'(p_bit_pos - 7'd1);
					if (idb != cmpb) begin
						dir = idb;
					end else begin
						if (p_bit_pos < p_last_discrep)
							dir = |(p_rom & bm);
						else
							dir = (p_bit_pos == p_last_discrep);
						if (!dir) begin
							p_zero_pos = p_bit_pos;
							if (p_bit_pos <= FAMILY_BITS)
								p_family_discrep = p_bit_pos[3:0];
						end
					end
					p_rom = dir ? (p_rom | bm) : (p_rom & ~bm);
					r.dir_valid = 1'b1;
					r.dir_bit = dir;
					if (p_bit_pos >= ROM_BITS) begin
						p_searching = 1'b0;
						r.done_res = 1'b1;
						p_last_discrep = p_zero_pos;
						if (p_last_discrep == 0)
							p_last_dev = 1'b1;
						r.found = 1'b1;
						if (p_rom[7:0] == 8'd0) begin
							clear_marks();
							r.found = 1'b0;
						end
						p_bit_pos = 7'd1;
					end else begin
						p_bit_pos = p_bit_pos + 7'd1;
					end
				end
			end
			CMD_CLEAR: clear_search();
			default: ;
		endcase
		r.rom_code = p_rom & CODE_MASK;
		r.last_device = p_last_dev;
		return r;
	endfunction

	task automatic drive_item(input logic [1:0] cmd, input logic pres, input logic idb,
			input logic cmpb, input logic typed, input result_t typed_res);
		int gap;
		result_t pred;
		gap = 0;
		if (!quiet && tx_idle_on && $urandom_range(0, 9) == 0)
			gap = $urandom_range(1, 16);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {5'd0, cmpb, idb, pres};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (!(cmd == CMD_UNUSED || (cmd == CMD_PAIR && !p_searching)))
			busy_items++;
		pred = search_step(cmd, pres, idb, cmpb);
		expected_results.push_back(typed ? typed_res : pred);
		last_res = pred;
		if (pred.done_res) begin
			if (pred.found)
				codes_found++;
			else
				failed_passes++;
			if (pred.found && pred.last_device)
				last_dev_ends++;
		end
	endtask

	// one device population, enumerated until the last device, a pass cap or the item target
	task automatic enumerate(input int pop);
		int n;
		int k;
		int pos;
		int passes;
		int cap;
		int flaw_kind;
		int flaw_pos;
		logic [7:0] alive;
		logic idb;
		logic cmpb;
		logic was_last;
		if (pop == 0) begin
			n = 1;
			dev_codes[0] = '1;
		end else if (pop == 1) begin
			n = 1;
			dev_codes[0] = 64'h8000_0000_0000_0000;
		end else begin
			n = $urandom_range(1, 6);
			for (k = 0; k < n; k++) begin
				dev_codes[k] = {$urandom, $urandom};
				if (k > 0 && $urandom_range(0, 1) == 1)
					dev_codes[k][31:0] = dev_codes[k-1][31:0];
				if ($urandom_range(0, 9) == 0)
					dev_codes[k][7:0] = 8'd0;
			end
		end
		if ($urandom_range(0, 3) == 0)
			drive_item(CMD_CLEAR, 1'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
		cap = 2 * n + 3;
		passes = 0;
		while (passes < cap && busy_items < ITEM_TARGET) begin
			passes++;
			tx_idle_on = ($urandom_range(0, 2) != 0);
			flaw_kind = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
			flaw_pos = $urandom_range(0, 63);
			if ($urandom_range(0, 15) == 0)
				drive_item(CMD_PAIR, 1'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
			if (!drained && busy_items >= 600) begin
				drained = 1'b1;
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (expected_results.size() != 0) @(posedge clk);
			end
			if (!held && busy_items >= 300 && pop > 1) begin
				held = 1'b1;
				hold_req = 1'b1;
			end
			was_last = p_last_dev;
			drive_item(CMD_BEGIN, flaw_kind != 1, 1'($urandom), 1'($urandom), 1'b0, '0);
			if (was_last)
				break;
			if (last_res.done_res)
				continue;
			alive = '0;
			for (k = 0; k < n; k++)
				alive[k] = 1'b1;
			for (pos = 0; pos < ROM_BITS; pos++) begin
				idb = 1'b1;
				cmpb = 1'b1;
				for (k = 0; k < n; k++) begin
					if (alive[k]) begin
						idb &= dev_codes[k][pos];
						cmpb &= ~dev_codes[k][pos];
					end
				end
				if (pos == flaw_pos) begin
					if (flaw_kind == 2)
						idb = ~idb;
					if (flaw_kind == 3) begin
						drive_item(CMD_CLEAR, 1'($urandom), 1'($urandom), 1'($urandom),
							1'b0, '0);
						break;
					end
					if (flaw_kind == 4)
						drive_item(CMD_UNUSED, 1'($urandom), 1'($urandom), 1'($urandom),
							1'b0, '0);
					if (flaw_kind == 5) begin
						idb = 1'b1;
						cmpb = 1'b1;
					end
					if (flaw_kind == 6) begin
						drive_item(CMD_BEGIN, 1'b1, 1'($urandom), 1'($urandom), 1'b0, '0);
						break;
					end
				end
				drive_item(CMD_PAIR, 1'($urandom), idb, cmpb, 1'b0, '0);
				if (last_res.done_res)
					break;
				for (k = 0; k < n; k++)
					if (alive[k] && dev_codes[k][pos] != last_res.dir_bit)
						alive[k] = 1'b0;
			end
			if (busy_items > ITEM_TARGET - 80)
				quiet = 1'b1;
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatches++;
		end
	endtask

	// result side: checks every transaction and drives tready with random stalls and one long hold
	initial begin
		int stall;
		int rate;
		int cyc;
		result_t got;
		result_t want;
		stall = 0;
		rate = 0;
		cyc = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata[68:0]);
				if (expected_results.size() == 0) begin
					$error("unexpected result transaction: %h", m_axis_tdata);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					checked++;
					check_field("dir_valid", 64'(want.dir_valid), 64'(got.dir_valid));
					check_field("dir_bit", 64'(want.dir_bit), 64'(got.dir_bit));
					check_field("done_res", 64'(want.done_res), 64'(got.done_res));
					check_field("found", 64'(want.found), 64'(got.found));
					check_field("rom_code", want.rom_code, got.rom_code);
					check_field("last_device", 64'(want.last_device),
						64'(got.last_device));
				end
			end
			cyc++;
			if (cyc % 50 == 0)
				rate = $urandom_range(0, 2);
			if (hold_req) begin
				hold_req = 1'b0;
				stall = 200;
			end
			if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else if (!quiet && rate != 0 &&
					$urandom_range(0, (rate == 1) ? 12 : 3) == 0) begin
				stall = $urandom_range(0, 15);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		int i;
		int pop;
		result_t typed_res;
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		clear_search();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (i = 0; i < 20; i++) begin
			typed_res = '0;
			typed_res.done_res = stim_rows[i].t_done;
			drive_item(stim_rows[i].cmd, stim_rows[i].presence, stim_rows[i].id_bit,
				stim_rows[i].cmp_bit, stim_rows[i].typed, typed_res);
		end
		pop = 0;
		while (busy_items < ITEM_TARGET) begin
			enumerate(pop);
			pop++;
		end
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("%0d transactions checked over %0d device populations", checked, pop);
		$display("%0d codes found, %0d last-device ends, %0d failed passes",
			codes_found, last_dev_ends, failed_passes);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("timeout");
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
